// ===== src/bnms_pkg.sv =====
// shared sizes and register indexes for the box suppression block
package bnms_pkg;
	localparam int MAX_CANDIDATES = 256;
	localparam int IDX_W = $clog2(MAX_CANDIDATES);
	localparam int CNT_W = IDX_W + 1;
	localparam int RESULT_CAP = 64;
	localparam int LIM_W = 7;
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BOXES = 4'd1;
	localparam logic [15:0] THR_RESET = 16'd32768;
	localparam logic [LIM_W-1:0] MAXB_RESET = 7'd10;
endpackage

// ===== src/box_non_max_suppression.sv =====
// greedy non-maximum suppression over a batch of boxes, one shared overlap pipeline
// Loading takes one box per cycle while in_stall is low.
// After the box with batch_end, the block stalls its input and runs rounds:
// a max-score scan over the n stored boxes, a fetch of the best box,
// and a suppression pass through the overlap pipeline per kept box while below the result limit.
// Reset (arst_n low) clears control state; thresholds return to 32768 and 10.
module box_non_max_suppression
	import bnms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   box_left,
	input  logic signed [15:0]   box_top,
	input  logic [15:0]          box_width,
	input  logic [15:0]          box_height,
	input  logic [7:0]           class_id,
	input  logic [15:0]          score,
	input  logic                 batch_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   kept_left,
	output logic signed [15:0]   kept_top,
	output logic [15:0]          kept_width,
	output logic [15:0]          kept_height,
	output logic [7:0]           kept_class,
	output logic [15:0]          kept_score,
	output logic                 final_box,
	output logic                 overflowed
);
	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_EMIT  = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_FWAIT = 3'd4;
	localparam logic [2:0] ST_SUPP  = 3'd5;
	localparam logic [2:0] ST_LAST  = 3'd6;

	logic [2:0] state_q;
	logic [15:0] thr_q;
	logic [LIM_W-1:0] maxb_q, lim;
	logic [CNT_W-1:0] n_q, k_q;
	logic drop_q;
	logic [LIM_W-1:0] kept_cnt_q;
	logic have_pend_q;
	logic found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [15:0] best_score_q;
	logic [MAX_CANDIDATES-1:0] alive_q;

	logic [63:0] geom_mem [MAX_CANDIDATES];
	logic [23:0] sc_mem [MAX_CANDIDATES];
	logic [63:0] geom_rd_q;
	logic [23:0] sc_rd_q;
	logic [IDX_W-1:0] rd_addr;

	// pending kept box, held until we know whether it is the last one
	logic [63:0] pend_geom_q;
	logic [23:0] pend_sc_q;
	logic [31:0] area_a_q;

	// overlap pipeline
	logic v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [15:0] ix_s2, iy_s2;
	logic [31:0] area_b_s2, area_b_s3;
	logic empty_s2, empty_s3, empty_s4;
	logic [31:0] inter_s3, inter_s4;
	logic [32:0] uni_s4;

	logic load_acc, out_free, issue, scan_done, supp_done, suppress;
	logic signed [17:0] la, lb, ta, tb, ea_x, eb_x, ea_y, eb_y, lo_x, lo_y, hi_x, hi_y;
	logic [17:0] dx, dy;
	logic [48:0] prod;
	logic [48:0] lhs;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_LOAD);
	assign load_acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign issue = ((state_q == ST_SCAN) || (state_q == ST_SUPP)) && (k_q < n_q);
	assign scan_done = (k_q == n_q) && !v_s1;
	assign supp_done = (k_q == n_q) && !v_s1 && !v_s2 && !v_s3 && !v_s4;
	assign rd_addr = (state_q == ST_FETCH) ? best_idx_q : k_q[IDX_W-1:0];

	// effective result limit
	always_comb begin
		if (maxb_q == '0) lim = LIM_W'(1);
		else if (maxb_q > LIM_W'(RESULT_CAP)) lim = LIM_W'(RESULT_CAP);
		else lim = maxb_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			maxb_q <= MAXB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_IOU_THRESHOLD) thr_q <= cfg_data;
			else if (cfg_index == REG_MAX_BOXES) maxb_q <= cfg_data[LIM_W-1:0];
		end
	end

	// box stores
	always_ff @(posedge clk) begin
		if (load_acc && (n_q < CNT_W'(MAX_CANDIDATES))) begin
			geom_mem[n_q[IDX_W-1:0]] <= {box_height, box_width, box_top, box_left};
			sc_mem[n_q[IDX_W-1:0]] <= {score, class_id};
		end
		geom_rd_q <= geom_mem[rd_addr];
		sc_rd_q <= sc_mem[rd_addr];
	end

	// overlap geometry against the pending box
	always_comb begin
		la = 18'(signed'(pend_geom_q[15:0]));
		ta = 18'(signed'(pend_geom_q[31:16]));
		lb = 18'(signed'(geom_rd_q[15:0]));
		tb = 18'(signed'(geom_rd_q[31:16]));
		ea_x = la + signed'({2'b00, pend_geom_q[47:32]});
		ea_y = ta + signed'({2'b00, pend_geom_q[63:48]});
		eb_x = lb + signed'({2'b00, geom_rd_q[47:32]});
		eb_y = tb + signed'({2'b00, geom_rd_q[63:48]});
		lo_x = (la > lb) ? la : lb;
		lo_y = (ta > tb) ? ta : tb;
		hi_x = (ea_x < eb_x) ? ea_x : eb_x;
		hi_y = (ea_y < eb_y) ? ea_y : eb_y;
		dx = (hi_x > lo_x) ? 18'(hi_x - lo_x) : '0;
		dy = (hi_y > lo_y) ? 18'(hi_y - lo_y) : '0;
		prod = 49'(thr_q) * 49'(uni_s4);
		lhs = {1'b0, inter_s4, 16'd0};
		suppress = v_s4 && !empty_s4 && (lhs > prod);
	end

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == ST_SUPP);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= k_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		ix_s2 <= dx[15:0];
		iy_s2 <= dy[15:0];
		area_b_s2 <= geom_rd_q[47:32] * geom_rd_q[63:48];
		empty_s2 <= (geom_rd_q[47:32] == '0) || (geom_rd_q[63:48] == '0) || (area_a_q == '0);
		idx_s3 <= idx_s2;
		inter_s3 <= ix_s2 * iy_s2;
		area_b_s3 <= area_b_s2;
		empty_s3 <= empty_s2;
		idx_s4 <= idx_s3;
		inter_s4 <= inter_s3;
		uni_s4 <= 33'(area_a_q) + 33'(area_b_s3) - 33'(inter_s3);
		empty_s4 <= empty_s3;
	end

	// pending box capture
	always_ff @(posedge clk) begin
		if (state_q == ST_FWAIT) begin
			pend_geom_q <= geom_rd_q;
			pend_sc_q <= sc_rd_q;
			area_a_q <= geom_rd_q[47:32] * geom_rd_q[63:48];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (((state_q == ST_EMIT) || (state_q == ST_LAST)) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (((state_q == ST_EMIT) || (state_q == ST_LAST)) && out_free) begin
			kept_left <= signed'(pend_geom_q[15:0]);
			kept_top <= signed'(pend_geom_q[31:16]);
			kept_width <= pend_geom_q[47:32];
			kept_height <= pend_geom_q[63:48];
			kept_class <= pend_sc_q[7:0];
			kept_score <= pend_sc_q[23:8];
			final_box <= (state_q == ST_LAST);
			overflowed <= drop_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q <= '0;
			k_q <= '0;
			drop_q <= 1'b0;
			kept_cnt_q <= '0;
			have_pend_q <= 1'b0;
			found_q <= 1'b0;
			best_idx_q <= '0;
			best_score_q <= '0;
			alive_q <= '1;
		end else begin
			if (issue) k_q <= k_q + CNT_W'(1);
			if (suppress) alive_q[idx_s4] <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (load_acc) begin
						if (n_q < CNT_W'(MAX_CANDIDATES)) begin
							alive_q[n_q[IDX_W-1:0]] <= 1'b1;
							n_q <= n_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (batch_end) begin
							state_q <= ST_SCAN;
							k_q <= '0;
							kept_cnt_q <= '0;
							have_pend_q <= 1'b0;
							found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (v_s1 && alive_q[idx_s1] && (!found_q || (sc_rd_q[23:8] > best_score_q))) begin
						found_q <= 1'b1;
						best_idx_q <= idx_s1;
						best_score_q <= sc_rd_q[23:8];
					end
					if (scan_done) begin
						if (found_q) state_q <= have_pend_q ? ST_EMIT : ST_FETCH;
						else state_q <= ST_LAST;
					end
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_FWAIT;
				end
				ST_FWAIT: begin
					alive_q[best_idx_q] <= 1'b0;
					have_pend_q <= 1'b1;
					kept_cnt_q <= kept_cnt_q + LIM_W'(1);
					found_q <= 1'b0;
					k_q <= '0;
					if ((kept_cnt_q + LIM_W'(1)) >= lim) state_q <= ST_LAST;
					else state_q <= ST_SUPP;
				end
				ST_SUPP: begin
					if (supp_done) begin
						state_q <= ST_SCAN;
						k_q <= '0;
					end
				end
				ST_LAST: begin
					if (out_free) begin
						state_q <= ST_LOAD;
						n_q <= '0;
						drop_q <= 1'b0;
						have_pend_q <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
